[hdl/itp_pkg.sv]
// Shared types, character codes and decode functions for the infix to postfix converter.
`default_nettype none

package itp_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WAIT
  } itp_state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } stack_cmd_t;

  // Operator precedence; zero for anything that is not an operator.
  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c) inside
      CH_PLUS, CH_MINUS:         p = 2'd1;
      CH_STAR, CH_SLASH, CH_PCT: p = 2'd2;
      CH_CARET:                  p = 2'd3;
      default:                   p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h30) && (c <= 8'h39));
  endfunction

endpackage

`default_nettype wire

[hdl/itp_stack.sv]
// Operator stack: memory with a fill count and registered reads of the top two entries.
`default_nettype none

module itp_stack
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int CNT_W = $clog2(STACK_DEPTH + 1),
  localparam int IDX_W = $clog2(STACK_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire stack_cmd_t       cmd,
  output logic      [CNT_W-1:0] count,
  output logic      [7:0]       top,
  output logic      [7:0]       next
);

  logic [7:0]       mem [STACK_DEPTH];
  logic [CNT_W-1:0] count_next;
  logic [IDX_W-1:0] wr_idx;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] next_idx;

  assign wr_idx   = count[IDX_W-1:0];
  assign top_idx  = IDX_W'(count - CNT_W'(1));
  assign next_idx = IDX_W'(count - CNT_W'(2));

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Entries are reread every cycle; data reflects the count of the cycle before.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_idx] <= cmd.wdata;
    end
    top  <= mem[top_idx];
    next <= mem[next_idx];
  end

endmodule

`default_nettype wire

[hdl/infix_to_postfix_converter.sv]
// Top level of the shunting-yard infix to postfix converter.
// Results wait in EVAL for a free output slot; an operand result then goes to the output register.
// The input is stalled until the sequencer is done with an item. Each stacked entry that is
//   popped and emitted takes a pop, then a WAIT visit for the registered stack read to settle.
// End of expression: every stacked entry is emitted in turn, or an empty marker if none is stacked.
// Reset (rst, synchronous, input stalled meanwhile): count, flag, sequencer, out_valid clear.
`default_nettype none

module infix_to_postfix_converter
  import itp_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] ch,
  input  wire logic       end_of_expr,
  // output channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [7:0] out_char,
  output logic            has_char,
  output logic            last_of_run,
  output logic            overflowed
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  itp_state_t       state;
  itp_state_t       state_next;

  // Item being worked on
  logic [7:0]       tok_ch;
  logic             tok_eoe;
  logic             tok_ovf;
  logic             any_out;
  logic             ovf_flag;

  // Stack view
  stack_cmd_t       cmd;
  logic [CNT_W-1:0] st_count;
  logic [7:0]       st_top;
  logic [7:0]       st_next;

  // Sequencer actions
  logic             accept;
  logic             slot_free;
  logic             emit;
  logic [7:0]       emit_char;
  logic             emit_has;
  logic             emit_last;
  logic             push_req;
  logic             pop_req;
  logic             done;
  logic             set_flag;
  logic             clr_flag;
  logic [1:0]       tok_prec;
  logic             st_empty;
  logic             st_full;
  logic             top_pops;
  logic             next_pops;

  // Hold the input off while busy and while reset is applied.
  assign in_stall  = (state != ST_IDLE) || rst;
  assign accept    = in_valid && !in_stall;
  // The output register may take a new result when empty or when its transfer completes.
  assign slot_free = !out_valid || !out_stall;

  assign tok_prec  = prec_of(tok_ch);
  assign st_empty  = (st_count == '0);
  assign st_full   = (st_count == CNT_W'(STACK_DEPTH));
  // Operator loop: top entry goes out while it binds at least as tightly as the new one.
  assign top_pops  = !st_empty && (st_top != CH_LPAREN) && (prec_of(st_top) >= tok_prec);
  assign next_pops = (st_count > CNT_W'(1)) && (st_next != CH_LPAREN) &&
                     (prec_of(st_next) >= tok_prec);

  itp_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .count(st_count),
    .top  (st_top),
    .next (st_next)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (done) begin
          state_next = ST_IDLE;
        end else if (pop_req) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_next = ST_EVAL;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Actions: one stack step per visit to EVAL; a result waits for a free output slot.
  always_comb begin
    emit      = 1'b0;
    emit_char = '0;
    emit_has  = 1'b0;
    emit_last = 1'b0;
    push_req  = 1'b0;
    pop_req   = 1'b0;
    done      = 1'b0;
    unique case (state)
      ST_EVAL: begin
        if (tok_eoe) begin
          if (!st_empty) begin
            if (slot_free) begin
              emit      = 1'b1;
              emit_char = st_top;
              emit_has  = 1'b1;
              emit_last = (st_count == CNT_W'(1));
              pop_req   = 1'b1;
            end
          end else if (any_out) begin
            done = 1'b1;
          end else if (slot_free) begin
            // empty flush: marker result with no character
            emit      = 1'b1;
            emit_last = 1'b1;
            done      = 1'b1;
          end
        end else if (is_operand(tok_ch)) begin
          if (slot_free) begin
            emit      = 1'b1;
            emit_char = tok_ch;
            emit_has  = 1'b1;
            emit_last = 1'b1;
            done      = 1'b1;
          end
        end else if (tok_ch == CH_LPAREN) begin
          push_req = 1'b1;
          done     = 1'b1;
        end else if (tok_ch == CH_RPAREN) begin
          if (st_empty) begin
            done = 1'b1;
          end else if (st_top == CH_LPAREN) begin
            // drop the matching '('
            pop_req = 1'b1;
            done    = 1'b1;
          end else if (slot_free) begin
            emit      = 1'b1;
            emit_char = st_top;
            emit_has  = 1'b1;
            emit_last = !((st_count > CNT_W'(1)) && (st_next != CH_LPAREN));
            pop_req   = 1'b1;
          end
        end else if (tok_prec != 2'd0) begin
          if (top_pops) begin
            if (slot_free) begin
              emit      = 1'b1;
              emit_char = st_top;
              emit_has  = 1'b1;
              emit_last = !next_pops;
              pop_req   = 1'b1;
            end
          end else begin
            push_req = 1'b1;
            done     = 1'b1;
          end
        end else begin
          done = 1'b1;
        end
      end
      ST_IDLE, ST_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  // Drop a push onto a full stack and mark it.
  assign cmd.push  = push_req && !st_full;
  assign cmd.pop   = pop_req;
  assign cmd.wdata = tok_ch;
  assign set_flag  = push_req && st_full;
  assign clr_flag  = done && tok_eoe;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      ovf_flag <= 1'b0;
      any_out  <= 1'b0;
    end else begin
      state <= state_next;
      if (set_flag) begin
        ovf_flag <= 1'b1;
      end else if (clr_flag) begin
        ovf_flag <= 1'b0;
      end
      if (accept) begin
        any_out <= 1'b0;
      end else if (emit) begin
        any_out <= 1'b1;
      end
    end
  end

  // Hold the accepted item; the flag is sampled as it stood before the item.
  always_ff @(posedge clk) begin
    if (accept) begin
      tok_ch  <= ch;
      tok_eoe <= end_of_expr;
      tok_ovf <= ovf_flag;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char    <= emit_char;
      has_char    <= emit_has;
      last_of_run <= emit_last;
      overflowed  <= tok_ovf;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    st_count <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_pop_step: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> (st_count == $past(st_count) - CNT_W'(1)))
    else $error("pop did not lower the stack count by one");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_char) |-> (last_of_run && (out_char == 8'h00)))
    else $error("empty marker not a lone zero result");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    set_flag |=> (ovf_flag && (st_count == CNT_W'(STACK_DEPTH))))
    else $error("dropped push changed the stack or lost the flag");
`endif

endmodule

`default_nettype wire
